@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked on i_clk, off while i_rst_n is low.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle.
`define BBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/bba_pkg.sv @@
// Package: constants, types and control structs of the buddy block allocator.
`default_nettype none
package bba_pkg;

    localparam int TOP_ORDER  = 10;
    localparam int NUM_ORDERS = TOP_ORDER + 1;
    localparam int LIST_DEPTH = 512;
    localparam int A_W        = 10;
    localparam int O_W        = 4;
    localparam int SZ_W       = 16;
    localparam int ID_W       = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int MEM_DEPTH  = NUM_ORDERS * LIST_DEPTH;
    localparam int MA_W       = $clog2(MEM_DEPTH);
    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
    localparam logic [ID_W-1:0] ID_LAST  = '1;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_ASRCH, S_FRONT, S_FRONT_CAP, S_REM, S_REM_WR,
        S_SPLIT_LO, S_SPLIT_HI, S_ACHK, S_FIND, S_FIND_CMP, S_MCHK,
        S_FAPP, S_GRANT, S_FREE_OK, S_FAIL
    } t_state;

    typedef enum logic [1:0] {
        MODE_TAKE, MODE_SPLIT, MODE_DUP, MODE_MERGE
    } t_mode;

    typedef enum logic [1:0] {
        RES_NONE, RES_GRANT, RES_FREE, RES_FAIL
    } t_res;

    typedef enum logic [1:0] {
        APP_ADDR, APP_VAL, APP_VAL_HI
    } t_app;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic rd_next;
        logic cap_val;
        logic shift_wr;
        logic cnt_dec;
        logic app;
        t_app app_sel;
        logic ord_inc;
        logic ord_dec;
        logic tgt_addr;
        logic tgt_buddy;
        logic merge;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic cnt_zero;
        logic idx_last;
        logic idx_end;
        logic match;
        logic ord_top;
        logic ord_over;
        logic ord_gt_k;
        logic misalign;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/core/bba_if.sv @@
// Request and response channel interfaces of the buddy block allocator.
`default_nettype none
interface bba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bba_pkg::SZ_W-1:0]     request_size;
    logic [bba_pkg::A_W-1:0]      free_address;
    logic [bba_pkg::O_W-1:0]      free_order;
    modport source (output valid, kind, request_size, free_address, free_order,
                    input ready);
    modport sink   (input valid, kind, request_size, free_address, free_order,
                    output ready);
endinterface

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         success;
    logic [bba_pkg::A_W-1:0]      block_address;
    logic [bba_pkg::O_W-1:0]      block_order;
    logic [bba_pkg::ID_W-1:0]     alloc_id;
    modport source (output valid, success, block_address, block_order, alloc_id,
                    input ready);
    modport sink   (input valid, success, block_address, block_order, alloc_id,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/bba_ctrl.sv @@
// Controller: sequences list scans, removals, splits and merges.
`default_nettype none
module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire bba_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output bba_pkg::t_cmd      o_cmd
);
    bba_pkg::t_state r_state, n_state;
    bba_pkg::t_mode  r_mode, n_mode;

    // state and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
            r_mode  <= bba_pkg::MODE_TAKE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd      = '0;
        o_in_ready = (r_state == bba_pkg::S_IDLE);
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bba_pkg::S_DISP;
                end
            end
            bba_pkg::S_DISP: begin
                if (!i_sts.kind) begin
                    if (!i_sts.cnt_zero) begin
                        o_cmd.idx_clr = 1'b1;
                        n_mode        = bba_pkg::MODE_TAKE;
                        n_state       = bba_pkg::S_FRONT;
                    end else begin
                        o_cmd.ord_inc = 1'b1;
                        n_state       = bba_pkg::S_ASRCH;
                    end
                end else if (i_sts.ord_over || i_sts.misalign) begin
                    n_state = bba_pkg::S_FAIL;
                end else begin
                    o_cmd.tgt_addr = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_mode         = bba_pkg::MODE_DUP;
                    n_state        = bba_pkg::S_FIND;
                end
            end
            // look upward for a nonempty list to split
            bba_pkg::S_ASRCH: begin
                if (i_sts.ord_over) begin
                    n_state = bba_pkg::S_FAIL;
                end else if (!i_sts.cnt_zero) begin
                    o_cmd.idx_clr = 1'b1;
                    n_mode        = bba_pkg::MODE_SPLIT;
                    n_state       = bba_pkg::S_FRONT;
                end else begin
                    o_cmd.ord_inc = 1'b1;
                end
            end
            bba_pkg::S_FRONT: begin
                o_cmd.rd = 1'b1;
                n_state  = bba_pkg::S_FRONT_CAP;
            end
            bba_pkg::S_FRONT_CAP: begin
                o_cmd.cap_val = 1'b1;
                n_state       = bba_pkg::S_REM;
            end
            // remove entry at idx: shift the tail down one beat at a time
            bba_pkg::S_REM: begin
                if (i_sts.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    case (r_mode)
                        bba_pkg::MODE_SPLIT: begin
                            o_cmd.ord_dec = 1'b1;
                            n_state       = bba_pkg::S_SPLIT_LO;
                        end
                        bba_pkg::MODE_TAKE: n_state = bba_pkg::S_GRANT;
                        default: begin
                            o_cmd.merge = 1'b1;
                            n_state     = bba_pkg::S_MCHK;
                        end
                    endcase
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = bba_pkg::S_REM_WR;
                end
            end
            bba_pkg::S_REM_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = bba_pkg::S_REM;
            end
            bba_pkg::S_SPLIT_LO: begin
                o_cmd.app     = 1'b1;
                o_cmd.app_sel = bba_pkg::APP_VAL;
                n_state       = bba_pkg::S_SPLIT_HI;
            end
            bba_pkg::S_SPLIT_HI: begin
                o_cmd.app     = 1'b1;
                o_cmd.app_sel = bba_pkg::APP_VAL_HI;
                n_state       = bba_pkg::S_ACHK;
            end
            bba_pkg::S_ACHK: begin
                if (i_sts.ord_gt_k) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = bba_pkg::S_FRONT;
                end else if (i_sts.cnt_zero) begin
                    n_state = bba_pkg::S_FAIL;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_mode        = bba_pkg::MODE_TAKE;
                    n_state       = bba_pkg::S_FRONT;
                end
            end
            // linear search of the current list for the target address
            bba_pkg::S_FIND: begin
                if (i_sts.idx_end) begin
                    n_state = (r_mode == bba_pkg::MODE_DUP) ? bba_pkg::S_MCHK
                                                            : bba_pkg::S_FAPP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = bba_pkg::S_FIND_CMP;
                end
            end
            bba_pkg::S_FIND_CMP: begin
                if (i_sts.match) begin
                    n_state = (r_mode == bba_pkg::MODE_DUP) ? bba_pkg::S_FAIL
                                                            : bba_pkg::S_REM;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = bba_pkg::S_FIND;
                end
            end
            bba_pkg::S_MCHK: begin
                if (i_sts.ord_top) begin
                    n_state = bba_pkg::S_FAPP;
                end else begin
                    o_cmd.tgt_buddy = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                    n_mode          = bba_pkg::MODE_MERGE;
                    n_state         = bba_pkg::S_FIND;
                end
            end
            bba_pkg::S_FAPP: begin
                o_cmd.app     = 1'b1;
                o_cmd.app_sel = bba_pkg::APP_ADDR;
                n_state       = bba_pkg::S_FREE_OK;
            end
            bba_pkg::S_GRANT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res = bba_pkg::RES_GRANT;
                    n_state   = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_FREE_OK: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res = bba_pkg::RES_FREE;
                    n_state   = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_FAIL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res = bba_pkg::RES_FAIL;
                    n_state   = bba_pkg::S_IDLE;
                end
            end
            default: n_state = bba_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/bba_dp.sv @@
// Datapath: free list memory, list counts, working registers, result register.
`default_nettype none
module bba_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bba_pkg::t_cmd               i_cmd,
    input  wire logic                        i_kind,
    input  wire logic [bba_pkg::SZ_W-1:0]    i_request_size,
    input  wire logic [bba_pkg::A_W-1:0]     i_free_address,
    input  wire logic [bba_pkg::O_W-1:0]     i_free_order,
    input  wire logic                        i_out_ready,
    output bba_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic                             o_success,
    output logic [bba_pkg::A_W-1:0]          o_block_address,
    output logic [bba_pkg::O_W-1:0]          o_block_order,
    output logic [bba_pkg::ID_W-1:0]         o_alloc_id
);
    localparam logic [bba_pkg::MA_W-1:0] TOP_ADDR0 =
        bba_pkg::MA_W'(bba_pkg::TOP_ORDER * bba_pkg::LIST_DEPTH);
    localparam logic [bba_pkg::O_W-1:0] TOP_ORD = bba_pkg::O_W'(bba_pkg::TOP_ORDER);

    logic [bba_pkg::A_W-1:0]   r_mem [bba_pkg::MEM_DEPTH];
    logic [bba_pkg::A_W-1:0]   r_q;
    logic                      r_rd_zero;
    logic                      r_top_fresh;
    logic [bba_pkg::CNT_W-1:0] r_cnt [bba_pkg::NUM_ORDERS];

    logic                      r_kind;
    logic [bba_pkg::O_W-1:0]   r_k, r_ord;
    logic [bba_pkg::A_W-1:0]   r_addr, r_tgt, r_val;
    logic [bba_pkg::CNT_W-1:0] r_idx;
    logic [bba_pkg::ID_W-1:0]  r_id;

    logic                      r_out_vld, r_out_ok;
    logic [bba_pkg::A_W-1:0]   r_out_addr;
    logic [bba_pkg::O_W-1:0]   r_out_ord;
    logic [bba_pkg::ID_W-1:0]  r_out_id;

    logic [bba_pkg::O_W-1:0]   k_calc;
    logic [bba_pkg::CNT_W-1:0] cur_cnt;
    logic [bba_pkg::CNT_W:0]   idx_p1;
    logic [bba_pkg::MA_W-1:0]  base, rd_addr, wr_addr;
    logic [bba_pkg::A_W-1:0]   wr_data, app_data, rdata, ord_bit;
    logic [bba_pkg::SZ_W:0]    low_mask;
    logic                      wr_en, app_ok, rd_en;

    // request rounded up to a power of two, clamped at the top order
    always_comb begin
        k_calc = TOP_ORD;
        for (int i = bba_pkg::TOP_ORDER - 1; i >= 0; i--) begin
            if (((bba_pkg::SZ_W + 1)'(1) << i) >= {1'b0, i_request_size}) begin
                k_calc = bba_pkg::O_W'(i);
            end
        end
    end

    // list geometry and status
    always_comb begin
        cur_cnt  = (r_ord <= TOP_ORD) ? r_cnt[r_ord] : '0;
        idx_p1   = {1'b0, r_idx} + (bba_pkg::CNT_W + 1)'(1);
        base     = bba_pkg::MA_W'(r_ord) * bba_pkg::MA_W'(bba_pkg::LIST_DEPTH);
        low_mask = ((bba_pkg::SZ_W + 1)'(1) << r_ord) - (bba_pkg::SZ_W + 1)'(1);
        ord_bit  = bba_pkg::A_W'((bba_pkg::SZ_W + 1)'(1) << r_ord);
        rdata    = r_rd_zero ? '0 : r_q;

        o_sts.kind     = r_kind;
        o_sts.cnt_zero = (cur_cnt == '0);
        o_sts.idx_last = (idx_p1 >= {1'b0, cur_cnt});
        o_sts.idx_end  = (r_idx >= cur_cnt);
        o_sts.match    = (rdata == r_tgt);
        o_sts.ord_top  = (r_ord == TOP_ORD);
        o_sts.ord_over = (r_ord > TOP_ORD);
        o_sts.ord_gt_k = (r_ord > r_k);
        o_sts.misalign = |(r_addr & low_mask[bba_pkg::A_W-1:0]);
        o_sts.out_busy = r_out_vld && !i_out_ready;
    end

    // memory port addressing
    always_comb begin
        rd_en   = i_cmd.rd || i_cmd.rd_next;
        rd_addr = base + (i_cmd.rd_next ? bba_pkg::MA_W'(idx_p1) : bba_pkg::MA_W'(r_idx));
        case (i_cmd.app_sel)
            bba_pkg::APP_VAL:    app_data = r_val;
            bba_pkg::APP_VAL_HI: app_data = r_val + ord_bit;
            default:             app_data = r_addr;
        endcase
        app_ok  = i_cmd.app && (cur_cnt < bba_pkg::CNT_W'(bba_pkg::LIST_DEPTH));
        wr_en   = i_cmd.shift_wr || app_ok;
        wr_addr = base + (i_cmd.shift_wr ? bba_pkg::MA_W'(r_idx) : bba_pkg::MA_W'(cur_cnt));
        wr_data = i_cmd.shift_wr ? rdata : app_data;
    end

    // free list memory, registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // first entry of the top list reads as zero until it is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_fresh <= 1'b1;
            r_rd_zero   <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_zero <= r_top_fresh && (rd_addr == TOP_ADDR0);
            end
            if (wr_en && wr_addr == TOP_ADDR0) begin
                r_top_fresh <= 1'b0;
            end
        end
    end

    // list counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bba_pkg::NUM_ORDERS; i++) begin
                r_cnt[i] <= (i == bba_pkg::TOP_ORDER) ? bba_pkg::CNT_W'(1) : '0;
            end
        end else if (app_ok) begin
            r_cnt[r_ord] <= cur_cnt + bba_pkg::CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt[r_ord] <= cur_cnt - bba_pkg::CNT_W'(1);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_k    <= k_calc;
            r_ord  <= i_kind ? i_free_order : k_calc;
            r_addr <= i_free_address;
        end else if (i_cmd.ord_inc) begin
            r_ord <= r_ord + bba_pkg::O_W'(1);
        end else if (i_cmd.ord_dec) begin
            r_ord <= r_ord - bba_pkg::O_W'(1);
        end else if (i_cmd.merge) begin
            r_addr <= r_addr & r_tgt;
            r_ord  <= r_ord + bba_pkg::O_W'(1);
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_p1[bba_pkg::CNT_W-1:0];
        end
        if (i_cmd.tgt_addr) begin
            r_tgt <= r_addr;
        end else if (i_cmd.tgt_buddy) begin
            r_tgt <= r_addr ^ ord_bit;
        end
        if (i_cmd.cap_val) begin
            r_val <= rdata;
        end
    end

    // allocation id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= bba_pkg::ID_FIRST;
        end else if (i_cmd.res == bba_pkg::RES_GRANT) begin
            r_id <= (r_id == bba_pkg::ID_LAST) ? bba_pkg::ID_FIRST : r_id + bba_pkg::ID_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.res != bba_pkg::RES_NONE) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        case (i_cmd.res)
            bba_pkg::RES_GRANT: begin
                r_out_ok   <= 1'b1;
                r_out_addr <= r_val;
                r_out_ord  <= r_ord;
                r_out_id   <= r_id;
            end
            bba_pkg::RES_FREE: begin
                r_out_ok   <= 1'b1;
                r_out_addr <= r_addr;
                r_out_ord  <= r_ord;
                r_out_id   <= '0;
            end
            bba_pkg::RES_FAIL: begin
                r_out_ok   <= 1'b0;
                r_out_addr <= '0;
                r_out_ord  <= '0;
                r_out_id   <= '0;
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_vld;
    assign o_success       = r_out_ok;
    assign o_block_address = r_out_addr;
    assign o_block_order   = r_out_ord;
    assign o_alloc_id      = r_out_id;
endmodule
`default_nettype wire

@@ rtl/core/buddy_block_allocator_unit.sv @@
// Top level of the buddy block allocator: controller, datapath, checks.
//
//  channel  dir  beat contents
//  i_req    in   kind, request_size, free_address, free_order
//  o_rsp    out  success, block_address, block_order, alloc_id
//
// One item at a time. An item's time grows with each free-list entry scanned or
// shifted; removing an entry shifts the tail of its list through the list
// memory, one entry at a time, a read followed by a write.
// Splits and merges repeat this once per order walked (up to ten).
// Reset is synchronous; the list memory needs no clearing pass.
// A stalled o_rsp holds its beat; the next request is still taken meanwhile.
`default_nettype none
`include "assert_macros.svh"
module buddy_block_allocator_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp
);
    bba_pkg::t_cmd w_cmd;
    bba_pkg::t_sts w_sts;
    logic          w_in_ready;

    // sequencer
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // lists and result
    bba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_kind          (i_req.kind),
        .i_request_size  (i_req.request_size),
        .i_free_address  (i_req.free_address),
        .i_free_order    (i_req.free_order),
        .i_out_ready     (o_rsp.ready),
        .o_sts           (w_sts),
        .o_out_valid     (o_rsp.valid),
        .o_success       (o_rsp.success),
        .o_block_address (o_rsp.block_address),
        .o_block_order   (o_rsp.block_order),
        .o_alloc_id      (o_rsp.alloc_id)
    );

    assign i_req.ready = w_in_ready;

    // checks
    `BBA_ASSERT_NXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    `BBA_ASSERT_IMP(a_rsp_from_work, $rose(o_rsp.valid), !$past(w_in_ready))
    `BBA_ASSERT_IMP(a_fail_zero, o_rsp.valid && !o_rsp.success, (o_rsp.block_address == '0) && (o_rsp.block_order == '0) && (o_rsp.alloc_id == '0))
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the buddy block allocator unit.
`default_nettype none
module testbench;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HELD_MAX       = 40;

    typedef struct packed {
        logic                     success;
        logic [bba_pkg::A_W-1:0]  addr;
        logic [bba_pkg::O_W-1:0]  ord;
        logic [bba_pkg::ID_W-1:0] id;
    } t_alloc_result;

    typedef struct packed {
        logic [bba_pkg::A_W-1:0] addr;
        logic [bba_pkg::O_W-1:0] ord;
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bba_req_if req_if();
    bba_rsp_if rsp_if();

    buddy_block_allocator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted allocator state
    logic [bba_pkg::A_W-1:0]  free_blocks [bba_pkg::NUM_ORDERS][$];
    logic [bba_pkg::ID_W-1:0] next_id;
    t_block                   held_blocks [$];

    t_alloc_result   pending_results [$];
    int              mismatches;
    int              tx_idle_pct;
    int              rx_idle_pct;
    int              rx_hold_cycles;
    int              quiet_cycles;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void list_push(int ord, logic [bba_pkg::A_W-1:0] addr);
        if (free_blocks[ord].size() < bba_pkg::LIST_DEPTH)
            free_blocks[ord].insert(free_blocks[ord].size(), addr);
    endfunction

    function automatic logic [bba_pkg::A_W-1:0] list_take(int ord);
        logic [bba_pkg::A_W-1:0] a;
        a = free_blocks[ord][0];
        free_blocks[ord].delete(0);
        return a;
    endfunction

    function automatic int list_index(int ord, logic [bba_pkg::A_W-1:0] addr);
        for (int i = 0; i < free_blocks[ord].size(); i++)
            if (free_blocks[ord][i] == addr)
                return i;
        return -1;
    endfunction

    // Allocate: round up, split the first larger block, grant front entry
    function automatic t_alloc_result predict_alloc(logic [bba_pkg::SZ_W-1:0] req);
        t_alloc_result res;
        int k;
        int j;
        logic [bba_pkg::A_W-1:0] a;
        res = '0;
        k = 0;
        while (k < bba_pkg::TOP_ORDER && (32'd1 << k) < req)
            k++;
        if (free_blocks[k].size() == 0) begin
            j = k + 1;
            while (j <= bba_pkg::TOP_ORDER && free_blocks[j].size() == 0)
                j++;
            if (j <= bba_pkg::TOP_ORDER) begin
                while (j > k) begin
                    a = list_take(j);
                    list_push(j - 1, a);
                    list_push(j - 1, a + bba_pkg::A_W'(32'd1 << (j - 1)));
                    j--;
                end
            end
        end
        if (free_blocks[k].size() == 0)
            return res;
        res.success = 1'b1;
        res.addr    = list_take(k);
        res.ord     = bba_pkg::O_W'(k);
        res.id      = next_id;
        next_id     = (next_id == bba_pkg::ID_LAST) ? bba_pkg::ID_FIRST : next_id + 1'b1;
        return res;
    endfunction

    // Free: reject bad order, misalignment and double free, then merge
    function automatic t_alloc_result predict_free(logic [bba_pkg::A_W-1:0] addr_in,
                                                   logic [bba_pkg::O_W-1:0] ord_in);
        t_alloc_result res;
        int ord;
        int idx;
        logic [bba_pkg::A_W-1:0] addr;
        logic [bba_pkg::A_W-1:0] buddy;
        res  = '0;
        ord  = ord_in;
        addr = addr_in;
        if (ord > bba_pkg::TOP_ORDER)
            return res;
        if ((32'(addr) & ((32'd1 << ord) - 1)) != 0)
            return res;
        if (list_index(ord, addr) >= 0)
            return res;
        while (ord < bba_pkg::TOP_ORDER) begin
            buddy = addr ^ bba_pkg::A_W'(32'd1 << ord);
            idx   = list_index(ord, buddy);
            if (idx < 0)
                break;
            free_blocks[ord].delete(idx);
            addr &= buddy;
            ord++;
        end
        list_push(ord, addr);
        res.success = 1'b1;
        res.addr    = addr;
        res.ord     = bba_pkg::O_W'(ord);
        return res;
    endfunction

    // Offer one beat; predict once it is taken. valid stays high afterwards.
    task automatic send_item(logic kind, logic [bba_pkg::SZ_W-1:0] size,
                             logic [bba_pkg::A_W-1:0] addr,
                             logic [bba_pkg::O_W-1:0] ord);
        t_alloc_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.kind         = kind;
        req_if.request_size = size;
        req_if.free_address = addr;
        req_if.free_order   = ord;
        req_if.valid        = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        if (kind == 1'b0) begin
            res = predict_alloc(size);
            if (res.success)
                held_blocks.insert(held_blocks.size(), {res.addr, res.ord});
        end else begin
            res = predict_free(addr, ord);
        end
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic alloc_units(logic [bba_pkg::SZ_W-1:0] size);
        send_item(1'b0, size, bba_pkg::A_W'($urandom), bba_pkg::O_W'($urandom));
    endtask

    task automatic free_block(logic [bba_pkg::A_W-1:0] addr, logic [bba_pkg::O_W-1:0] ord);
        send_item(1'b1, bba_pkg::SZ_W'($urandom), addr, ord);
    endtask

    task automatic free_held_at(int idx);
        t_block b;
        b = held_blocks[idx];
        held_blocks.delete(idx);
        free_block(b.addr, b.ord);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    // Extremes, every special case, then release everything held
    task automatic test_directed();
        alloc_units(16'd0);
        alloc_units(16'hFFFF);           // whole memory, not free: fails
        free_held_at(0);                  // merges back to one block
        alloc_units(16'hFFFF);           // clamped to whole memory
        free_block(10'd0, 4'd10);         // top order never merges
        free_block(10'd0, 4'd10);         // double free
        free_block(10'd0, 4'd11);
        free_block(10'd0, 4'd15);
        free_block(10'd1, 4'd1);          // misaligned
        free_block(10'h3FF, 4'd0);        // free a block inside a free one
        alloc_units(16'd1);
        alloc_units(16'd2);
        alloc_units(16'd3);
        alloc_units(16'd5);
        alloc_units(16'd512);
        alloc_units(16'd513);
        alloc_units(16'd1024);
        alloc_units(16'h5555);
        while (held_blocks.size() != 0)
            free_held_at(0);
        free_block(10'h200, 4'd9);
        wait_drained();
    endtask

    // Mostly well-formed alloc/free traffic, some noise
    task automatic test_random(int n);
        int r;
        int ord;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 85) begin
                if (held_blocks.size() > HELD_MAX ||
                    (held_blocks.size() != 0 && $urandom_range(1)))
                    free_held_at($urandom_range(held_blocks.size() - 1));
                else if ($urandom_range(9) == 0)
                    alloc_units(bba_pkg::SZ_W'($urandom));
                else
                    alloc_units(bba_pkg::SZ_W'($urandom_range(64)));
            end else if (r < 92) begin
                // double free of a block sitting in a list, else a bad order
                ord = $urandom_range(bba_pkg::TOP_ORDER);
                if (free_blocks[ord].size() != 0)
                    free_block(free_blocks[ord][0], bba_pkg::O_W'(ord));
                else
                    free_block(bba_pkg::A_W'($urandom),
                               bba_pkg::O_W'($urandom_range(11, 15)));
            end else if (r < 96) begin
                free_block(bba_pkg::A_W'($urandom), bba_pkg::O_W'($urandom));
            end else begin
                alloc_units(bba_pkg::SZ_W'($urandom_range(256, 1023)));
            end
        end
        wait_drained();
    endtask

    // Long response stall while the sender keeps offering beats
    task automatic test_backpressure();
        int saved;
        saved = tx_idle_pct;
        tx_idle_pct = 0;
        rx_hold_cycles = 400;
        for (int i = 0; i < 30; i++) begin
            if (held_blocks.size() != 0 && $urandom_range(1))
                free_held_at($urandom_range(held_blocks.size() - 1));
            else
                alloc_units(bba_pkg::SZ_W'($urandom_range(32)));
        end
        wait_drained();
        tx_idle_pct = saved;
    endtask

    // Response ready with random stalls and a forced hold-off
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rsp_if.ready   <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each response beat with the oldest prediction
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: success=%0d addr=%0d ord=%0d id=%0d",
                             rsp_if.success, rsp_if.block_address,
                             rsp_if.block_order, rsp_if.alloc_id);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (rsp_if.success !== want.success ||
                    rsp_if.block_address !== want.addr ||
                    rsp_if.block_order !== want.ord ||
                    rsp_if.alloc_id !== want.id) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.success, want.addr, want.ord, want.id,
                                 rsp_if.success, rsp_if.block_address,
                                 rsp_if.block_order, rsp_if.alloc_id);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid        = 1'b0;
        req_if.kind         = 1'b0;
        req_if.request_size = '0;
        req_if.free_address = '0;
        req_if.free_order   = '0;
        rsp_if.ready        = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        rx_hold_cycles = 0;
        tx_idle_pct    = 9;
        rx_idle_pct    = 76;
        foreach (free_blocks[i])
            free_blocks[i].delete();
        free_blocks[bba_pkg::TOP_ORDER].insert(0, '0);
        next_id = bba_pkg::ID_FIRST;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(550);
        tx_idle_pct = 76;
        rx_idle_pct = 9;
        test_random(550);
        test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(550);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ buddy_block_allocator_unit.f @@
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dp.sv
rtl/core/buddy_block_allocator_unit.sv
dv/testbench.sv
